// File: design/tkh_pkg.sv
// Package for the top-K min-heap tracker: field widths, constant codes and the
// command and status structs between the controller and the datapath.
// Depends on nothing; every other design file but tkh_ram imports it.
`default_nettype none

package tkh_pkg;

   localparam int unsigned VAL_W  = 32;
   localparam int unsigned IDX_W  = 32;
   localparam int unsigned KEEP_W = 7;
   localparam int unsigned WORD_W = VAL_W + IDX_W;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_POP    = 1'b1;

   typedef struct packed {
      logic accept;
      logic append;
      logic rd_up;
      logic rd_down;
      logic rd_root;
      logic rd_pop;
      logic wr_cur;
      logic move_up;
      logic move_down;
      logic pop_take;
      logic load_res;
      logic load_empty;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic at_root;
      logic up_move;
      logic has_left;
      logic down_move;
      logic drop;
   } sts_type;

endpackage

`default_nettype wire

// File: design/tkh_ram.sv
// Generic simple RAM with one write port and two registered read ports.
// Depends on nothing.
`default_nettype none

module tkh_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_a,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_b,
   output logic      [WIDTH-1:0]                       rdata_a,
   output logic      [WIDTH-1:0]                       rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

`default_nettype wire

// File: design/tkh_dp.sv
// Datapath of the top-K min-heap tracker: heap RAM, moving entry, position,
// entry count, keep count register and result register.
// Depends on tkh_pkg and tkh_ram.
`default_nettype none

module tkh_dp #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire tkh_pkg::cmd_type            cmd,
   output tkh_pkg::sts_type                 st,
   input  wire logic [tkh_pkg::IDX_W-1:0]   item_index,
   input  wire logic [tkh_pkg::VAL_W-1:0]   item_value,
   input  wire logic                        csr_valid,
   input  wire logic [tkh_pkg::KEEP_W-1:0]  csr_wdata,
   output logic      [tkh_pkg::IDX_W-1:0]   popped_index,
   output logic      [tkh_pkg::VAL_W-1:0]   popped_value,
   output logic                             was_empty
);
   import tkh_pkg::*;

   localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = AW + 2;
   localparam int unsigned EW = (CW > KEEP_W) ? CW : KEEP_W;

   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [AW-1:0]     pos_ff, pos_in;
   logic [IDX_W-1:0]  cur_idx_ff, cur_idx_in;
   logic [VAL_W-1:0]  cur_val_ff, cur_val_in;
   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic [VAL_W-1:0]  res_val_ff, res_val_in;
   logic              res_empty_ff, res_empty_in;

   logic [EW-1:0]     keep_x, cap_x, eff_k;
   logic [XW-1:0]     left_x, right_x, count_x;
   logic [AW-1:0]     parent, child_pos, last_pos;
   logic [WORD_W-1:0] rd_a, rd_b, child_word, wdata;
   logic [AW-1:0]     raddr_a, raddr_b;
   logic [VAL_W-1:0]  a_val, b_val;
   logic              cur_below_a, left_less, right_ok, take_right, we;

   assign keep_x  = EW'(keep_ff);
   assign cap_x   = EW'(CAPACITY);
   assign eff_k   = (keep_ff == '0) ? EW'(1) : ((keep_x > cap_x) ? cap_x : keep_x);

   assign left_x  = {1'b0, pos_ff, 1'b1};
   assign right_x = left_x + XW'(1);
   assign count_x = XW'(count_ff);
   assign parent  = AW'(pos_ff - AW'(1)) >> 1;
   assign last_pos = AW'(count_ff - CW'(1));

   assign a_val = rd_a[VAL_W-1:0];
   assign b_val = rd_b[VAL_W-1:0];

   assign cur_below_a = $signed(cur_val_ff) < $signed(a_val);
   assign left_less   = $signed(a_val) < $signed(cur_val_ff);
   assign right_ok    = right_x < count_x;
   assign take_right  = right_ok && (left_less ? ($signed(b_val) < $signed(a_val))
                                               : ($signed(b_val) < $signed(cur_val_ff)));
   assign child_pos   = take_right ? AW'(right_x) : AW'(left_x);
   assign child_word  = take_right ? rd_b : rd_a;

   always_comb begin
      st.empty     = (count_ff == '0);
      st.full      = (EW'(count_ff) >= eff_k);
      st.at_root   = (pos_ff == '0);
      st.up_move   = cur_below_a;
      st.has_left  = (left_x < count_x);
      st.down_move = left_less || take_right;
      st.drop      = cur_below_a;
   end

   always_comb begin
      raddr_a = '0;
      raddr_b = '0;
      priority if (cmd.rd_up) begin
         raddr_a = parent;
      end else if (cmd.rd_down) begin
         raddr_a = AW'(left_x);
         raddr_b = AW'(right_x);
      end else if (cmd.rd_root) begin
         raddr_a = '0;
      end else if (cmd.rd_pop) begin
         raddr_b = last_pos;
      end
   end

   assign we    = cmd.wr_cur || cmd.move_up || cmd.move_down;
   assign wdata = cmd.wr_cur ? {cur_idx_ff, cur_val_ff} : (cmd.move_down ? child_word : rd_a);

   tkh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock   (clock),
      .we      (we),
      .waddr   (pos_ff),
      .wdata   (wdata),
      .raddr_a (raddr_a),
      .raddr_b (raddr_b),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   always_comb begin
      keep_in      = csr_valid ? csr_wdata : keep_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      cur_idx_in   = cur_idx_ff;
      cur_val_in   = cur_val_ff;
      res_idx_in   = res_idx_ff;
      res_val_in   = res_val_ff;
      res_empty_in = res_empty_ff;
      if (cmd.accept) begin
         cur_idx_in = item_index;
         cur_val_in = item_value;
         pos_in     = '0;
         if (cmd.append) begin
            pos_in   = AW'(count_ff);
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.move_up) begin
         pos_in = parent;
      end
      if (cmd.move_down) begin
         pos_in = child_pos;
      end
      if (cmd.pop_take) begin
         cur_idx_in = rd_b[WORD_W-1:VAL_W];
         cur_val_in = b_val;
         count_in   = count_ff - CW'(1);
         pos_in     = '0;
      end
      if (cmd.load_res) begin
         res_idx_in   = cmd.load_empty ? '0 : rd_a[WORD_W-1:VAL_W];
         res_val_in   = cmd.load_empty ? '0 : a_val;
         res_empty_in = cmd.load_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff  <= KEEP_RESET;
         count_ff <= '0;
      end else begin
         keep_ff  <= keep_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      cur_idx_ff   <= cur_idx_in;
      cur_val_ff   <= cur_val_in;
      res_idx_ff   <= res_idx_in;
      res_val_ff   <= res_val_in;
      res_empty_ff <= res_empty_in;
   end

   assign popped_index = res_idx_ff;
   assign popped_value = res_val_ff;
   assign was_empty    = res_empty_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("Entry count exceeds the capacity.");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      cmd.append |-> !st.full)
      else $error("Append issued into a full store.");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_take |-> !st.empty)
      else $error("Pop removed an entry from an empty store.");
`endif

endmodule

`default_nettype wire

// File: design/tkh_ctrl.sv
// Controller of the top-K min-heap tracker: sequences inserts, pops and the
// sift steps, and owns the input and result handshakes. Depends on tkh_pkg.
`default_nettype none

module tkh_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic             opcode,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   input  wire tkh_pkg::sts_type st,
   output tkh_pkg::cmd_type      cmd
);
   import tkh_pkg::*;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_UP_RD    = 4'd1;
   localparam logic [3:0] S_UP_CMP   = 4'd2;
   localparam logic [3:0] S_ROOT_RD  = 4'd3;
   localparam logic [3:0] S_ROOT_CMP = 4'd4;
   localparam logic [3:0] S_DN_RD    = 4'd5;
   localparam logic [3:0] S_DN_CMP   = 4'd6;
   localparam logic [3:0] S_POP_RD   = 4'd7;
   localparam logic [3:0] S_POP_CMP  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (opcode == OP_POP) begin
                  state_in = S_POP_RD;
               end else if (!st.full) begin
                  cmd.append = 1'b1;
                  state_in   = S_UP_RD;
               end else begin
                  state_in = S_ROOT_RD;
               end
            end
         end
         S_UP_RD: begin
            if (st.at_root) begin
               cmd.wr_cur = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_up = 1'b1;
               state_in  = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (st.up_move) begin
               cmd.move_up = 1'b1;
               state_in    = S_UP_RD;
            end else begin
               cmd.wr_cur = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_ROOT_RD: begin
            cmd.rd_root = 1'b1;
            state_in    = S_ROOT_CMP;
         end
         S_ROOT_CMP: begin
            state_in = st.drop ? S_IDLE : S_DN_RD;
         end
         S_DN_RD: begin
            if (!st.has_left) begin
               cmd.wr_cur = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.rd_down = 1'b1;
               state_in    = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (st.down_move) begin
               cmd.move_down = 1'b1;
               state_in      = S_DN_RD;
            end else begin
               cmd.wr_cur = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_POP_RD: begin
            cmd.rd_pop = 1'b1;
            if (out_free) begin
               if (st.empty) begin
                  cmd.load_res   = 1'b1;
                  cmd.load_empty = 1'b1;
                  state_in       = S_IDLE;
               end else begin
                  state_in = S_POP_CMP;
               end
            end
         end
         S_POP_CMP: begin
            cmd.pop_take = 1'b1;
            cmd.load_res = 1'b1;
            state_in     = S_DN_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_res || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_res |-> out_free)
      else $error("Result loaded over a beat that was not taken.");

   a_pop_cmp_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_CMP) |-> ($past(state_ff) == S_POP_RD))
      else $error("Pop compare entered without its read.");

   a_dn_cmp_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DN_CMP) |-> ($past(state_ff) == S_DN_RD))
      else $error("Sift-down compare entered without its read.");
`endif

endmodule

`default_nettype wire

// File: design/top_k_min_heap_tracker.sv
// Top level of the top-K min-heap tracker: keeps the K largest (index, value)
// pairs of a stream in a binary min-heap held in RAM.
// Depends on tkh_pkg, tkh_ctrl, tkh_dp and tkh_ram.
//
// The req channel carries one beat per operation: tuser selects insert or pop,
// tdata carries the index and signed Q16.16 value of an insert. A pop returns
// one beat on the rsp channel with the removed smallest pair, or was_empty set
// when the store held nothing; an insert returns nothing. The csr channel sets
// K (zero acts as one, values above CAPACITY saturate) and is always ready; it
// is to be written only while the block is idle; the block does not enforce it.
// Items are handled one at a time: req_tready is high only while idle. An insert
// below K sifts the new entry up from the end of the heap; a full-store insert is
// dropped when its value lies below the root and otherwise replaces the root and
// sifts down. A pop takes the root as its result, moves the last entry to the root
// and sifts it down; a pop of an empty store only returns was_empty. Each level
// is a registered RAM read followed by a compare and write step. The pop result is
// registered; a stalled rsp channel holds it and only holds back the next pop,
// not inserts.
// Reset empties the store and sets K to 64; the RAM contents need no clearing.
`default_nettype none

module top_k_min_heap_tracker #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // Bits from the lowest: item_index [31:0], item_value [63:32].
   input  wire logic [tkh_pkg::IDX_W+tkh_pkg::VAL_W-1:0] req_tdata,
   // Bits from the lowest: opcode [0].
   input  wire logic                                 req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // Bits from the lowest: popped_index [31:0], popped_value [63:32].
   output logic      [tkh_pkg::IDX_W+tkh_pkg::VAL_W-1:0] rsp_tdata,
   // Bits from the lowest: was_empty [0].
   output logic                                      rsp_tuser,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [tkh_pkg::KEEP_W-1:0]           csr_wdata
);
   import tkh_pkg::*;

   cmd_type          cmd;
   sts_type          st;
   logic [IDX_W-1:0] popped_index;
   logic [VAL_W-1:0] popped_value;
   logic             was_empty;

   assign csr_ready = 1'b1;

   tkh_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .opcode     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   tkh_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .st           (st),
      .item_index   (req_tdata[IDX_W-1:0]),
      .item_value   (req_tdata[IDX_W+VAL_W-1:IDX_W]),
      .csr_valid    (csr_valid),
      .csr_wdata    (csr_wdata),
      .popped_index (popped_index),
      .popped_value (popped_value),
      .was_empty    (was_empty)
   );

   assign rsp_tdata = {popped_value, popped_index};
   assign rsp_tuser = was_empty;

endmodule

`default_nettype wire

// File: sim/top_k_min_heap_tracker_tb.sv
// Self-checking testbench for the top-K min-heap tracker: drives insert and pop beats,
// mirrors the heap in a local predictor and checks every pop result beat.
// Depends on tkh_pkg and the top_k_min_heap_tracker design files.
`default_nettype none

module top_k_min_heap_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tkh_pkg::*;

   localparam int CAP         = 64;
   localparam int SETTLE      = 40;
   localparam int HOLD_CYCLES = 400;
   localparam int RANDOM_OPS  = 1250;

   typedef struct packed {
      logic        op;
      logic [31:0] idx;
      logic [31:0] val;
   } heap_op_type;

   typedef struct packed {
      logic [31:0] idx;
      logic [31:0] val;
      logic        empty;
   } pop_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [IDX_W+VAL_W-1:0]     req_tdata = '0;
   logic                       req_tuser = OP_INSERT;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [IDX_W+VAL_W-1:0]     rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [KEEP_W-1:0]          csr_wdata = '0;

   top_k_min_heap_tracker #(.CAPACITY(CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Mirror of the heap contents and the keep register.
   logic signed [31:0] kept_val [CAP];
   logic        [31:0] kept_idx [CAP];
   int                 kept_count = 0;
   int                 keep_reg   = int'(KEEP_RESET);

   heap_op_type  op_backlog [$];
   pop_beat_type expected_pops [$];
   int        queued_ops   = 0;
   int        accepted_ops = 0;
   int        mismatches   = 0;
   int        send_idle_pct = 13;
   int        recv_idle_pct = 80;
   logic      hold_req = 1'b0;
   int        hold_left;

   function automatic int clamp_keep(input int k);
      if (k == 0) return 1;
      if (k > CAP) return CAP;
      return k;
   endfunction

   function automatic void swap_slots(input int a, input int b);
      logic signed [31:0] v;
      logic        [31:0] i;
      v = kept_val[a];
      kept_val[a] = kept_val[b];
      kept_val[b] = v;
      i = kept_idx[a];
      kept_idx[a] = kept_idx[b];
      kept_idx[b] = i;
   endfunction

   function automatic void sift_root_down();
      int pos;
      int left;
      int right;
      int best;
      pos = 0;
      forever begin
         left  = 2 * pos + 1;
         right = 2 * pos + 2;
         best  = pos;
         if (left >= kept_count) return;
         if (kept_val[left] < kept_val[best]) best = left;
         if (right < kept_count && kept_val[right] < kept_val[best]) best = right;
         if (best == pos) return;
         swap_slots(pos, best);
         pos = best;
      end
   endfunction

   function automatic void keep_largest(input logic [31:0] idx, input logic signed [31:0] val);
      int pos;
      int parent;
      if (kept_count < clamp_keep(keep_reg)) begin
         pos = kept_count;
         kept_val[pos] = val;
         kept_idx[pos] = idx;
         kept_count++;
         while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (!(kept_val[pos] < kept_val[parent])) break;
            swap_slots(pos, parent);
            pos = parent;
         end
      end else if (kept_count > 0) begin
         if (val < kept_val[0]) return;
         kept_val[0] = val;
         kept_idx[0] = idx;
         sift_root_down();
      end
   endfunction

   function automatic pop_beat_type pop_smallest();
      pop_beat_type r;
      if (kept_count == 0) begin
         r.idx   = '0;
         r.val   = '0;
         r.empty = 1'b1;
         return r;
      end
      r.idx   = kept_idx[0];
      r.val   = kept_val[0];
      r.empty = 1'b0;
      kept_count--;
      kept_val[0] = kept_val[kept_count];
      kept_idx[0] = kept_idx[kept_count];
      sift_root_down();
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < 100) $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   // Request driver: takes the next operation from the backlog when the channel is free.
   always @(posedge clock) begin
      heap_op_type next_op;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            accepted_ops++;
            if (req_tuser == OP_POP)
               expected_pops.insert(expected_pops.size(), pop_smallest());
            else keep_largest(req_tdata[31:0], req_tdata[63:32]);
         end
         if (!req_tvalid || req_tready) begin
            if (op_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_op = op_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= next_op.op;
               req_tdata  <= {next_op.val, next_op.idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver, with a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_req) begin
         rsp_tready <= 1'b0;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      pop_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_pops.size() == 0) begin
            report_mismatch("result beat arrived with no pop outstanding");
         end else begin
            want = expected_pops.pop_front();
            if (rsp_tuser !== want.empty)
               report_mismatch($sformatf("was_empty %b, expected %b", rsp_tuser, want.empty));
            if (rsp_tdata[31:0] !== want.idx)
               report_mismatch($sformatf("popped_index %h, expected %h",
                                         rsp_tdata[31:0], want.idx));
            if (rsp_tdata[63:32] !== want.val)
               report_mismatch($sformatf("popped_value %h, expected %h",
                                         rsp_tdata[63:32], want.val));
         end
      end
   end

   function automatic logic [31:0] pick_value();
      int t;
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3, 4: begin
            t = int'($urandom_range(15)) - 8;
            return t * 65536;
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic push_op(input logic op, input logic [31:0] idx, input logic [31:0] val);
      heap_op_type o;
      o.op  = op;
      o.idx = idx;
      o.val = val;
      op_backlog.insert(op_backlog.size(), o);
      queued_ops++;
   endtask

   task automatic wait_quiet();
      do @(posedge clock);
      while (accepted_ops != queued_ops || expected_pops.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_keep(input int k);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= k[KEEP_W-1:0];
      do @(posedge clock);
      while (!csr_ready);
      keep_reg = k;
      csr_valid <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int keep_plan [10] = '{64, 5, 127, 1, 0, 33, 2, 64, 17, 100};
      int phase;
      int random_ops;
      int k;
      int n_fill;
      int inserted;
      int drain;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: pop on empty, field extremes, ties, ignored insert fields on pops.
      push_op(OP_POP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_op(OP_INSERT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      push_op(OP_INSERT, 32'h0000_0000, 32'h8000_0000);
      push_op(OP_INSERT, 32'h5555_5555, 32'h0000_0000);
      push_op(OP_INSERT, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
      push_op(OP_INSERT, 32'h0000_0001, 32'h0001_0000);
      push_op(OP_INSERT, 32'h0000_0002, 32'h0000_0000);
      push_op(OP_INSERT, 32'h0000_0003, 32'h0000_0000);
      repeat (8) push_op(OP_POP, $urandom, $urandom);
      wait_quiet();

      // A keep count of zero acts as one; an equal value replaces the root.
      write_keep(0);
      push_op(OP_INSERT, 32'h0000_0010, 32'h0005_0000);
      push_op(OP_INSERT, 32'h0000_0011, 32'h0005_0000);
      push_op(OP_INSERT, 32'h0000_0012, 32'h0003_0000);
      push_op(OP_POP, 32'h0, 32'h0);
      push_op(OP_POP, 32'h0, 32'h0);
      wait_quiet();

      // Back-pressure: the receiver holds off while pops keep coming.
      write_keep(64);
      repeat (40) push_op(OP_INSERT, $urandom, pick_value());
      wait_quiet();
      @(posedge clock);
      hold_req <= 1'b1;
      @(posedge clock);
      hold_req <= 1'b0;
      repeat (10) begin
         push_op(OP_POP, $urandom, $urandom);
         push_op(OP_POP, $urandom, $urandom);
         push_op(OP_INSERT, $urandom, pick_value());
      end
      wait_quiet();
      repeat (30) push_op(OP_POP, $urandom, $urandom);
      wait_quiet();

      random_ops = 0;
      phase = 0;
      while (random_ops < RANDOM_OPS) begin
         if (random_ops < RANDOM_OPS / 3) begin
            send_idle_pct = 13;
            recv_idle_pct = 80;
         end else if (random_ops < 2 * RANDOM_OPS / 3) begin
            send_idle_pct = 80;
            recv_idle_pct = 13;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         k = (phase < 10) ? keep_plan[phase] : int'($urandom_range(127));
         wait_quiet();
         write_keep(k);
         n_fill = ($urandom_range(3) == 0) ? int'($urandom_range(70, 110))
                                           : int'($urandom_range(4, 50));
         inserted = 0;
         repeat (n_fill) begin
            if ($urandom_range(99) < 22) begin
               push_op(OP_POP, $urandom, $urandom);
            end else begin
               push_op(OP_INSERT, $urandom, pick_value());
               inserted++;
            end
         end
         random_ops += n_fill;
         // The first phase is never drained, so the next keep count can land below the fill.
         if (phase > 0 && $urandom_range(1) == 1) begin
            drain = ((inserted < clamp_keep(k)) ? inserted : clamp_keep(k))
                    + int'($urandom_range(1, 3));
            repeat (drain) push_op(OP_POP, $urandom, $urandom);
            random_ops += drain;
         end
         phase++;
      end

      wait_quiet();
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
